### rtl/core/spqdk_pkg.sv
`default_nettype none
package spqdk_pkg;
	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_POP    = 2'd1,
		FN_DECR   = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_FULL    = 3'd2,
		ST_NOKEY   = 3'd3,
		ST_NOTLESS = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_PLACE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;     // latch request
		logic remove;   // shift out search result / head
		logic insert;   // stable insert of latched entry
		logic pop_head; // record popped head
		logic out_load; // capture result
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  empty;
		logic  full;
		logic  found;
		logic  less;
	} sts_t;
endpackage
`default_nettype wire

### rtl/core/spqdk_ctrl.sv
`default_nettype none
module spqdk_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_fire,
	input  wire logic           out_free,
	input  wire spqdk_pkg::sts_t sts,
	output spqdk_pkg::cmd_t     cmd,
	output logic                in_ready,
	output logic [2:0]          status
);
	import spqdk_pkg::*;

	state_t state_q, state_d;
	status_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
		end
	end

	assign status = st_q;

	always_comb begin
		state_d = state_q;
		st_d = st_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				st_d = ST_OK;
				state_d = S_OUT;
				case (sts.func)
					FN_INSERT: begin
						if (sts.full) st_d = ST_FULL;
						else cmd.insert = 1'b1;
					end
					FN_POP: begin
						if (sts.empty) st_d = ST_EMPTY;
						else begin
							cmd.pop_head = 1'b1;
							cmd.remove = 1'b1;
						end
					end
					FN_DECR: begin
						if (sts.empty) st_d = ST_EMPTY;
						else if (!sts.found) st_d = ST_NOKEY;
						else if (!sts.less) st_d = ST_NOTLESS;
						else begin
							cmd.remove = 1'b1;
							state_d = S_PLACE;
						end
					end
					default: ;
				endcase
			end
			S_PLACE: begin
				cmd.insert = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### rtl/core/spqdk_dp.sv
`default_nettype none
module spqdk_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire spqdk_pkg::cmd_t      cmd,
	input  wire logic [1:0]           in_func,
	input  wire logic [15:0]          in_key,
	input  wire logic signed [31:0]   in_prio,
	output spqdk_pkg::sts_t           sts,
	output logic                      popped_valid,
	output logic [15:0]               popped_key,
	output logic signed [31:0]        popped_prio,
	output logic [15:0]               head_key,
	output logic signed [31:0]        head_prio,
	output logic                      empty_flag,
	output logic [4:0]                fill_count
);
	import spqdk_pkg::*;

	logic [KEY_BITS-1:0] keys_q [CAPACITY];
	logic signed [31:0]  prios_q [CAPACITY];
	logic [CNT_W-1:0]    cnt_q;
	func_t               func_q;
	logic [KEY_BITS-1:0] key_q;
	logic signed [31:0]  prio_q;
	logic                pv_q;
	logic [KEY_BITS-1:0] pk_q;
	logic signed [31:0]  pp_q;

	// per-slot match and stable-insert flags
	logic [CAPACITY-1:0] match, le;
	logic [CAPACITY-1:0] first;
	logic [IDX_W-1:0]    tgt;
	logic                found;
	logic signed [31:0]  tgt_prio;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = (CNT_W'(i) < cnt_q) && (keys_q[i] == key_q);
			le[i] = (CNT_W'(i) < cnt_q) && (prios_q[i] <= prio_q);
		end
	end

	// sorted: first matching slot has the smallest prio, earliest on ties
	always_comb begin
		first = match & ~(match - CAPACITY'(1));
		found = |match;
		tgt = '0;
		for (int i = 0; i < CAPACITY; i++)
			if (first[i]) tgt = IDX_W'(i);
		tgt_prio = prios_q[tgt];
	end

	always_comb begin
		sts.func = func_q;
		sts.empty = (cnt_q == '0);
		sts.full = (cnt_q == CNT_W'(CAPACITY));
		sts.found = found;
		sts.less = prio_q < tgt_prio;
	end

	logic [IDX_W-1:0] rm_idx;
	assign rm_idx = (func_q == FN_POP) ? '0 : tgt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.remove) cnt_q <= cnt_q - CNT_W'(1);
		else if (cmd.insert) cnt_q <= cnt_q + CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(in_func);
			key_q <= in_key[KEY_BITS-1:0];
			prio_q <= in_prio;
			pv_q <= 1'b0;
			pk_q <= '0;
			pp_q <= '0;
		end
		if (cmd.pop_head) begin
			pv_q <= 1'b1;
			pk_q <= keys_q[0];
			pp_q <= prios_q[0];
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.remove && IDX_W'(i) >= rm_idx && i < CAPACITY - 1) begin
				keys_q[i] <= keys_q[i+1];
				prios_q[i] <= prios_q[i+1];
			end else if (cmd.insert) begin
				if (!le[i]) begin
					if (i == 0 || le[i-1]) begin
						keys_q[i] <= key_q;
						prios_q[i] <= prio_q;
					end else begin
						keys_q[i] <= keys_q[i-1];
						prios_q[i] <= prios_q[i-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			popped_valid <= 1'b0;
			empty_flag <= 1'b1;
			fill_count <= '0;
		end else if (cmd.out_load) begin
			popped_valid <= pv_q;
			empty_flag <= (cnt_q == '0);
			fill_count <= 5'(cnt_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			popped_key <= 16'(pk_q);
			popped_prio <= pp_q;
			head_key <= (cnt_q == '0) ? 16'd0 : 16'(keys_q[0]);
			head_prio <= (cnt_q == '0) ? -32'sd1 : prios_q[0];
		end
	end
endmodule
`default_nettype wire

### rtl/core/stable_priority_queue_decrease_key_core.sv
// Flow: a request is latched, executed (a decrease-key removes, then reinserts), and its
// result is registered before the next request is accepted; the shifting entry array is used
// at most twice per request by a single controller.
// Reset: arst_n asynchronous active low empties the queue and clears the output valid,
// status and flag registers; entry contents and output key/prio fields are not cleared.
`default_nettype none
module stable_priority_queue_decrease_key_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata, // func[1:0], key[17:2], prio[49:18], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [111:0]     m_tdata  // status[2:0], popped_valid[3], popped_key[19:4],
	                                  // popped_prio[51:20], head_key[67:52],
	                                  // head_prio[99:68], empty_flag[100],
	                                  // fill_count[105:101], zero pad
);
	import spqdk_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_fire, out_free;
	logic [2:0] status, status_o;
	logic pv, ef;
	logic [15:0] pk, hk;
	logic signed [31:0] pp, hp;
	logic [4:0] fc;
	logic mv_q;

	assign in_fire = s_tvalid && s_tready;
	assign out_free = !mv_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
			status_o <= '0;
		end else begin
			if (cmd.out_load) begin
				mv_q <= 1'b1;
				status_o <= status;
			end else if (m_tready) mv_q <= 1'b0;
		end
	end

	spqdk_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.sts(sts), .cmd(cmd), .in_ready(s_tready), .status(status)
	);

	spqdk_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_func(s_tdata[1:0]), .in_key(s_tdata[17:2]), .in_prio(s_tdata[49:18]),
		.sts(sts), .popped_valid(pv), .popped_key(pk), .popped_prio(pp),
		.head_key(hk), .head_prio(hp), .empty_flag(ef), .fill_count(fc)
	);

	assign m_tvalid = mv_q;
	assign m_tdata = {6'b0, fc, ef, hp, hk, pp, pk, pv, status_o};
endmodule
`default_nettype wire
